[rtl/core/sfp_pkg.sv]
package sfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [BYTE_W-1:0] RESET_HEADER = 8'h5A;
    localparam logic [BYTE_W-1:0] RESET_TAIL   = 8'hA5;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE   = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        POS_HEADER   = 3'd0,
        POS_HI_1     = 3'd1,
        POS_LO_1     = 3'd2,
        POS_HI_2     = 3'd3,
        POS_LO_2     = 3'd4,
        POS_STATUS   = 3'd5,
        POS_CHECKSUM = 3'd6,
        POS_TAIL     = 3'd7
    } t_pos;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] tail_byte;
    } t_cfg;

    // held input beat between the input stage and the parser
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_beat;

endpackage

[rtl/core/sfp_intf.sv]
interface sfp_byte_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if import sfp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] first_reading;
    logic [VALUE_W-1:0] second_reading;
    logic [BYTE_W-1:0]  status_value;

    modport source (output valid, output first_reading, output second_reading,
                    output status_value, input ready);
    modport sink   (input valid, input first_reading, input second_reading,
                    input status_value, output ready);
endinterface

interface sfp_cfg_if import sfp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [BYTE_W-1:0]    wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/core/sensor_frame_parser.sv]
// channel   dir   modport  payload
// i_rx      in    sink     rx_byte[7:0]
// o_res     out   source   first_reading[15:0], second_reading[15:0], status_value[7:0]
// i_cfg     in    sink     reg_index[3:0], wr_data[7:0] (0 header_byte, 1 tail_byte)
//
// one byte per cycle sustained while results are taken; a taken tail beat goes through the input
// register, then the parser, into the result register
// i_rst_n is synchronous, active low; header_byte and tail_byte return to 0x5A and 0xA5
// a stalled result holds the parser and then the input register; i_rx.ready drops
// only when both are full
// configuration writes are always taken, one per cycle
module sensor_frame_parser import sfp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfp_byte_if.sink  i_rx,
    sfp_res_if.source o_res,
    sfp_cfg_if.sink   i_cfg
);

    t_cfg     cfg;
    t_in_beat beat;
    logic     advance;

    sfp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg.valid),
        .i_wr_index (i_cfg.reg_index),
        .i_wr_data  (i_cfg.wr_data),
        .o_wr_ready (i_cfg.ready),
        .o_cfg      (cfg)
    );

    sfp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_rx.valid),
        .i_rx_byte (i_rx.rx_byte),
        .o_ready   (i_rx.ready),
        .i_advance (advance),
        .o_beat    (beat)
    );

    sfp_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_beat           (beat),
        .o_advance        (advance),
        .o_res_valid      (o_res.valid),
        .i_res_ready      (o_res.ready),
        .o_first_reading  (o_res.first_reading),
        .o_second_reading (o_res.second_reading),
        .o_status_value   (o_res.status_value)
    );

endmodule

[rtl/core/sfp_cfg_regs.sv]
module sfp_cfg_regs import sfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_valid,
    input  logic [CFG_IDX_W-1:0] i_wr_index,
    input  logic [BYTE_W-1:0]    i_wr_data,
    output logic                 o_wr_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_wr_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_valid) begin
            case (i_wr_index)
                CFG_HEADER_BYTE: n_cfg.header_byte = i_wr_data;
                CFG_TAIL_BYTE:   n_cfg.tail_byte   = i_wr_data;
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte <= RESET_HEADER;
            r_cfg.tail_byte   <= RESET_TAIL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/sfp_in_stage.sv]
module sfp_in_stage import sfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_ready,
    input  logic              i_advance,
    output t_in_beat          o_beat
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              n_valid;

    // slot frees up whenever the parser takes the held beat
    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid && !i_advance;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_beat.valid   = r_valid;
    assign o_beat.rx_byte = r_byte;

endmodule

[rtl/core/sfp_parser.sv]
module sfp_parser import sfp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_in_beat           i_beat,
    output logic               o_advance,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [VALUE_W-1:0] o_first_reading,
    output logic [VALUE_W-1:0] o_second_reading,
    output logic [BYTE_W-1:0]  o_status_value
);

    t_pos               r_pos;
    t_pos               n_pos;
    logic [BYTE_W-1:0]  r_sum;
    logic [BYTE_W-1:0]  n_sum;
    logic [VALUE_W-1:0] r_first;
    logic [VALUE_W-1:0] n_first;
    logic [VALUE_W-1:0] r_second;
    logic [VALUE_W-1:0] n_second;
    logic [BYTE_W-1:0]  r_status;
    logic [BYTE_W-1:0]  n_status;

    logic               r_res_valid;
    logic [VALUE_W-1:0] r_res_iron;
    logic [VALUE_W-1:0] r_res_air;
    logic [BYTE_W-1:0]  r_res_status;

    logic               fire;
    logic               emit;
    logic [BYTE_W-1:0]  b;

    assign o_advance = !r_res_valid || i_res_ready;
    assign fire      = i_beat.valid && o_advance;
    assign b         = i_beat.rx_byte;

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_first  = r_first;
        n_second = r_second;
        n_status = r_status;
        emit     = 1'b0;
        case (r_pos)
            POS_HEADER: begin
                if (b == i_cfg.header_byte) begin
                    n_sum = b;
                    n_pos = POS_HI_1;
                end
            end
            POS_HI_1: begin
                n_first = {b, 8'h00};
                n_sum   = r_sum + b;
                n_pos   = POS_LO_1;
            end
            POS_LO_1: begin
                n_first = {r_first[VALUE_W-1:BYTE_W], b};
                n_sum   = r_sum + b;
                n_pos   = POS_HI_2;
            end
            POS_HI_2: begin
                n_second = {b, 8'h00};
                n_sum    = r_sum + b;
                n_pos    = POS_LO_2;
            end
            POS_LO_2: begin
                n_second = {r_second[VALUE_W-1:BYTE_W], b};
                n_sum    = r_sum + b;
                n_pos    = POS_STATUS;
            end
            POS_STATUS: begin
                n_status = b;
                n_sum    = r_sum + b;
                n_pos    = POS_CHECKSUM;
            end
            POS_CHECKSUM: begin
                // a bad checksum byte is not retried as a header
                n_pos = (b == r_sum) ? POS_TAIL : POS_HEADER;
            end
            POS_TAIL: begin
                emit  = (b == i_cfg.tail_byte);
                n_pos = POS_HEADER;
            end
            default: begin
                n_pos = POS_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HEADER;
            r_sum    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_status <= '0;
        end else if (fire) begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_first  <= n_first;
            r_second <= n_second;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (o_advance) begin
            r_res_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_res_iron   <= r_first;
            r_res_air    <= r_second;
            r_res_status <= r_status;
        end
    end

    assign o_res_valid      = r_res_valid;
    assign o_first_reading  = r_res_iron;
    assign o_second_reading = r_res_air;
    assign o_status_value   = r_res_status;

endmodule

[rtl/core/sfp_checker.sv]
module sfp_checker import sfp_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_rx_valid,
    input logic               i_rx_ready,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic [VALUE_W-1:0] i_first_reading,
    input logic [VALUE_W-1:0] i_second_reading,
    input logic [BYTE_W-1:0]  i_status_value
);

    logic rx_acc;
    assign rx_acc = i_rx_valid && i_rx_ready;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before it was taken");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_first_reading) && $stable(i_second_reading) && $stable(i_status_value))
        else $error("stalled result changed");

    // a fresh result must trace back to a beat taken on the input channel
    a_res_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(rx_acc, 2))
        else $error("result appeared without a matching tail beat");

    // only one beat of buffering behind a stalled result
    a_buffer_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_acc && i_res_valid && !i_res_ready |=> !i_rx_ready || i_res_ready)
        else $error("input taken with no room behind stalled result");

endmodule

bind sensor_frame_parser sfp_checker u_sfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_rx_valid       (i_rx.valid),
    .i_rx_ready       (i_rx.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_first_reading  (o_res.first_reading),
    .i_second_reading (o_res.second_reading),
    .i_status_value   (o_res.status_value)
);

[tb/sv/tb_sensor_frame_parser.sv]
`timescale 1ns / 100ps

module tb_sensor_frame_parser;
    import sfp_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] iron;
        logic [VALUE_W-1:0] air;
        logic [BYTE_W-1:0]  status;
    } t_reading;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              typed;
        t_reading          want;
    } t_row;

    localparam int DIR_N       = 25;
    localparam int PHASE_N     = 5;
    localparam int PHASE_BYTES = 90;
    localparam int SETTLE_CYC  = 4;
    localparam int DRAIN_CYC   = 5000;

    logic i_clk;
    logic i_rst_n;

    sfp_byte_if rx_if ();
    sfp_res_if  res_if ();
    sfp_cfg_if  cfg_if ();

    sensor_frame_parser u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // directed bytes: stray byte, all-ones frame, bad checksum equal to the header,
    // stray tail, header values inside a frame closed by a wrong tail
    t_row dir_rows [DIR_N] = '{
        '{8'h00, 1'b0, '0},
        '{8'h5A, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h55, 1'b0, '0},
        '{8'hA5, 1'b1, '{16'hFFFF, 16'hFFFF, 8'hFF}},
        '{8'h5A, 1'b0, '0}, '{8'h12, 1'b0, '0}, '{8'h34, 1'b0, '0}, '{8'h56, 1'b0, '0},
        '{8'h78, 1'b0, '0}, '{8'h9A, 1'b0, '0}, '{8'h5A, 1'b0, '0}, '{8'hA5, 1'b0, '0},
        '{8'h5A, 1'b0, '0}, '{8'h5A, 1'b0, '0}, '{8'h5A, 1'b0, '0}, '{8'h5A, 1'b0, '0},
        '{8'h5A, 1'b0, '0}, '{8'h5A, 1'b0, '0}, '{8'h1C, 1'b0, '0}, '{8'h5A, 1'b0, '0}
    };

    // mirror of the parser
    logic [BYTE_W-1:0]  hdr_cfg;
    logic [BYTE_W-1:0]  tail_cfg;
    t_pos               pos;
    logic [BYTE_W-1:0]  sum_acc;
    logic [VALUE_W-1:0] first_acc;
    logic [VALUE_W-1:0] second_acc;
    logic [BYTE_W-1:0]  status_acc;

    t_reading reading_q [$];

    int err_cnt    = 0;
    int bytes_sent = 0;
    int send_idle  = 0;
    int res_stall  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_sensor_frame_parser: FAIL");
        $finish;
    end

    task automatic parse_byte(input logic [BYTE_W-1:0] b, output logic got, output t_reading r);
        got = 1'b0;
        r   = '0;
        case (pos)
            POS_HEADER: begin
                if (b == hdr_cfg) begin
                    sum_acc = b;
                    pos     = POS_HI_1;
                end
            end
            POS_HI_1: begin
                first_acc = {b, 8'h00};
                sum_acc   = sum_acc + b;
                pos       = POS_LO_1;
            end
            POS_LO_1: begin
                first_acc = first_acc | VALUE_W'(b);
                sum_acc   = sum_acc + b;
                pos       = POS_HI_2;
            end
            POS_HI_2: begin
                second_acc = {b, 8'h00};
                sum_acc    = sum_acc + b;
                pos        = POS_LO_2;
            end
            POS_LO_2: begin
                second_acc = second_acc | VALUE_W'(b);
                sum_acc    = sum_acc + b;
                pos        = POS_STATUS;
            end
            POS_STATUS: begin
                status_acc = b;
                sum_acc    = sum_acc + b;
                pos        = POS_CHECKSUM;
            end
            POS_CHECKSUM: begin
                pos = (b == sum_acc) ? POS_TAIL : POS_HEADER;
            end
            default: begin
                if (b == tail_cfg) begin
                    got = 1'b1;
                    r   = '{first_acc, second_acc, status_acc};
                end
                pos = POS_HEADER;
            end
        endcase
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            rx_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        logic     got;
        t_reading r;
        put_byte(b);
        parse_byte(b, got, r);
        if (got)
            reading_q.push_back(r);
    endtask

    // drop valid, wait for every pending reading, then let the pipeline settle
    task automatic drain();
        int n;
        n = 0;
        @(negedge i_clk);
        rx_if.valid <= 1'b0;
        while (reading_q.size() != 0 && n < DRAIN_CYC) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == CFG_HEADER_BYTE)
            hdr_cfg = d;
        else if (idx == CFG_TAIL_BYTE)
            tail_cfg = d;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_sequence();
        logic [BYTE_W-1:0] pay [5];
        logic [BYTE_W-1:0] ck;
        logic [BYTE_W-1:0] tl;
        int                kind;
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(4, 1)) send_byte(rand_byte());
        end else if (kind < 16) begin
            // frame cut short, the next sequence runs into it
            send_byte(hdr_cfg);
            repeat ($urandom_range(4, 1)) send_byte(rand_byte());
        end else begin
            ck = hdr_cfg;
            foreach (pay[i]) begin
                pay[i] = rand_byte();
                ck     = ck + pay[i];
            end
            if (kind < 24)
                ck = ck ^ BYTE_W'($urandom_range(255, 1));
            tl = tail_cfg;
            if (kind >= 24 && kind < 32)
                tl = tl ^ BYTE_W'($urandom_range(255, 1));
            send_byte(hdr_cfg);
            foreach (pay[i])
                send_byte(pay[i]);
            send_byte(ck);
            send_byte(tl);
        end
    endtask

    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= res_stall);
    end

    always @(posedge i_clk) begin : res_mon
        t_reading want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (reading_q.size() == 0) begin
                $error("unexpected beat: first_reading %h second_reading %h status_value %h",
                       res_if.first_reading, res_if.second_reading, res_if.status_value);
                err_cnt++;
            end else begin
                want = reading_q.pop_front();
                if (res_if.first_reading !== want.iron) begin
                    $error("first_reading: expected %h, actual %h",
                           want.iron, res_if.first_reading);
                    err_cnt++;
                end
                if (res_if.second_reading !== want.air) begin
                    $error("second_reading: expected %h, actual %h",
                           want.air, res_if.second_reading);
                    err_cnt++;
                end
                if (res_if.status_value !== want.status) begin
                    $error("status_value: expected %h, actual %h",
                           want.status, res_if.status_value);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : stim
        logic              got;
        t_reading          r;
        logic [BYTE_W-1:0] h;
        logic [BYTE_W-1:0] t;
        int                start;
        int                nseq;

        i_rst_n          <= 1'b0;
        rx_if.valid      <= 1'b0;
        rx_if.rx_byte    <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.reg_index <= CFG_HEADER_BYTE;
        cfg_if.wr_data   <= '0;

        hdr_cfg    = RESET_HEADER;
        tail_cfg   = RESET_TAIL;
        pos        = POS_HEADER;
        sum_acc    = '0;
        first_acc  = '0;
        second_acc = '0;
        status_acc = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            put_byte(dir_rows[i].rx_byte);
            parse_byte(dir_rows[i].rx_byte, got, r);
            if (dir_rows[i].typed)
                reading_q.push_back(dir_rows[i].want);
            else if (got)
                reading_q.push_back(r);
        end

        for (int p = 0; p < PHASE_N; p++) begin
            drain();
            case (p % 4)
                0: begin send_idle = 0;  res_stall = 0;  end
                1: begin send_idle = 62; res_stall = 0;  end
                2: begin send_idle = 0;  res_stall = 62; end
                default: begin send_idle = 19; res_stall = 19; end
            endcase
            case (p)
                0: begin h = '0; t = '1; end
                1: begin h = '1; t = '0; end
                2: begin h = RESET_HEADER; t = RESET_TAIL; end
                3: begin h = BYTE_W'($urandom_range(255)); t = BYTE_W'($urandom_range(255)); end
                default: begin h = BYTE_W'($urandom_range(255)); t = h; end
            endcase
            write_reg(CFG_HEADER_BYTE, h);
            write_reg(CFG_TAIL_BYTE, t);
            // unused index, must leave both registers alone
            write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, CFG_TAIL_BYTE + 1)),
                      BYTE_W'($urandom_range(255)));

            start = bytes_sent;
            nseq  = 0;
            while (bytes_sent - start < PHASE_BYTES) begin
                send_sequence();
                nseq++;
                if (nseq == 3)
                    drain();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (reading_q.size() != 0) begin
            $error("%0d readings never arrived", reading_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("tb_sensor_frame_parser: PASS");
        else
            $display("tb_sensor_frame_parser: FAIL");
        $finish;
    end

endmodule
